### src/pes_pkg.sv
// Shared types and constants for the periodic event scheduler.
// Used by the RTL and the testbench; depends on nothing else.
package pes_pkg;

    localparam int unsigned MAX_SOURCES_DEF = 64;
    localparam int unsigned MAX_EMITS_DEF   = 64;
    localparam int unsigned TIME_BITS_DEF   = 48;

    localparam int unsigned ID_W     = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned OTIME_W  = 48;

    // Item modes. The reserved mode is ignored by the block.
    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_EMIT     = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [ID_W-1:0]     source_id;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  emit_count;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    event_id;
        logic [OTIME_W-1:0] event_time;
        logic               last;
        logic               table_empty;
    } out_item_t;

    // Operation broadcast to every cell in the row.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } cell_op_t;

endpackage

### src/pes_cell.sv
// One cell of the sorted scheduler row: holds one entry and compares it
// against the broadcast entry. Depends on pes_pkg.
module pes_cell #(
    parameter int unsigned TB = pes_pkg::TIME_BITS_DEF,
    parameter int unsigned SW = 6,
    parameter int unsigned EW = 1 + TB + pes_pkg::ID_W + pes_pkg::PERIOD_W + SW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pes_pkg::cell_op_t op,
    input  logic             is_head,
    input  logic [EW-1:0]    bcast,
    input  logic [EW-1:0]    left_entry,
    input  logic             left_lt,
    input  logic [EW-1:0]    right_entry,
    input  logic             right_lt,
    output logic [EW-1:0]    entry,
    output logic             lt
);

    localparam int unsigned KW = TB + pes_pkg::ID_W + SW;

    logic              valid_reg, valid_next;
    logic [EW-2:0]     data_reg, data_next;
    logic [KW-1:0]     own_key, b_key;
    logic [EW-1:0]     pick;

    assign entry = {valid_reg, data_reg};

    // Sort key: due time, then id, then insertion slot.
    assign own_key = {data_reg[EW-2 -: TB + pes_pkg::ID_W], data_reg[SW-1:0]};
    assign b_key   = {bcast[EW-2 -: TB + pes_pkg::ID_W], bcast[SW-1:0]};
    assign lt      = valid_reg && (own_key < b_key);

    // Choose the new content from self, a neighbor or the broadcast entry.
    always_comb
    begin
        pick = entry;
        if (op.push)
        begin
            if (lt)
                pick = entry;
            else if (left_lt || is_head)
                pick = bcast;
            else
                pick = left_entry;
        end
        else if (op.pop)
        begin
            if (right_lt)
                pick = right_entry;
            else if (lt || is_head)
                pick = bcast;
            else
                pick = entry;
        end
        valid_next = op.clear ? 1'b0 : pick[EW-1];
        data_next  = pick[EW-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### src/periodic_event_scheduler.sv
// Periodic event scheduler top level: control sequencer, output register
// and a sorted row of pes_cell instances. Depends on pes_pkg and pes_cell.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | in_data  (pes_pkg::in_item_t)
//   output  | out_valid | out_stall | out_data (pes_pkg::out_item_t)
//
// Add and clear transactions act on the row when accepted. An emit transaction
// with a nonzero count yields one event per count, capped at MAX_EMITS (one
// empty-table result if the table is empty); each event pops the row head and
// reinserts it in sorted order. Input stall stays high while they are produced.
// The output register lets the next input be taken while the final result waits.
// Reset empties the row at once; no clearing pass is needed.
// Output stall holds the sequencer in the emit state without losing events.
module periodic_event_scheduler #(
    parameter int unsigned MAX_SOURCES = pes_pkg::MAX_SOURCES_DEF,
    parameter int unsigned MAX_EMITS   = pes_pkg::MAX_EMITS_DEF,
    parameter int unsigned TIME_BITS   = pes_pkg::TIME_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pes_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pes_pkg::out_item_t out_data
);

    localparam int unsigned TB = TIME_BITS;
    localparam int unsigned SW = $clog2(MAX_SOURCES);
    localparam int unsigned CW = $clog2(MAX_SOURCES + 1);
    localparam int unsigned PW = pes_pkg::PERIOD_W;
    localparam int unsigned IW = pes_pkg::ID_W;
    localparam int unsigned EW = 1 + TB + IW + PW + SW;
    localparam int unsigned LW = pes_pkg::COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      left_reg, left_next;
    logic               out_valid_reg, out_valid_next;
    pes_pkg::out_item_t out_reg, out_next;

    pes_pkg::cell_op_t  op;
    logic [EW-1:0]      bcast;
    logic [EW-1:0]      ent   [MAX_SOURCES+1];
    logic               ltv   [MAX_SOURCES+1];

    logic               accept, fire;
    logic [TB-1:0]      head_due, next_due;
    logic [IW-1:0]      head_id;
    logic [PW-1:0]      head_period;
    logic [SW-1:0]      head_slot;
    logic [TB:0]        due_sum;
    logic [63:0]        due_wide;
    logic [LW-1:0]      emit_sat;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign fire      = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Head of the row and its next due time, saturated.
    assign head_due    = ent[0][EW-2 -: TB];
    assign head_id     = ent[0][EW-2-TB -: IW];
    assign head_period = ent[0][SW +: PW];
    assign head_slot   = ent[0][SW-1:0];
    assign due_sum     = {1'b0, head_due} + (TB+1)'(head_period);
    assign next_due    = due_sum[TB] ? {TB{1'b1}} : due_sum[TB-1:0];
    assign due_wide    = 64'(head_due);
    assign emit_sat    = (in_data.emit_count > LW'(MAX_EMITS)) ? LW'(MAX_EMITS)
                                                               : in_data.emit_count;

    // Sequencer, broadcast entry and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        op             = '0;
        bcast          = {1'b1, next_due, head_id, head_period, head_slot};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.mode)
                        pes_pkg::MODE_ADD:
                        begin
                            bcast = {1'b1, TB'(in_data.period), in_data.source_id,
                                     in_data.period, count_reg[SW-1:0]};
                            if (count_reg < CW'(MAX_SOURCES))
                            begin
                                op.push    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pes_pkg::MODE_EMIT:
                        begin
                            if (in_data.emit_count != '0)
                            begin
                                left_next  = emit_sat;
                                state_next = ST_EMIT;
                            end
                        end
                        pes_pkg::MODE_CLEAR:
                        begin
                            op.clear   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_next   = '{event_id: '0, event_time: '0,
                                       last: 1'b1, table_empty: 1'b1};
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        op.pop     = 1'b1;
                        out_next   = '{event_id: head_id,
                                       event_time: due_wide[pes_pkg::OTIME_W-1:0],
                                       last: (left_reg == LW'(1)), table_empty: 1'b0};
                        left_next  = left_reg - 1'b1;
                        if (left_reg == LW'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Row of cells kept sorted by due time, id and slot.
    assign ent[MAX_SOURCES] = '0;
    assign ltv[MAX_SOURCES] = 1'b0;

    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_cell
        pes_cell #(
            .TB(TB),
            .SW(SW),
            .EW(EW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .is_head    (i == 0),
            .bcast      (bcast),
            .left_entry ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i-1]),
            .left_lt    ((i == 0) ? 1'b1 : ltv[(i == 0) ? 0 : i-1]),
            .right_entry(ent[i+1]),
            .right_lt   (ltv[i+1]),
            .entry      (ent[i]),
            .lt         (ltv[i])
        );
    end

    // Checks on the sequencer and the row.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SOURCES))
        else $error("entry count exceeds table size");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ent[0][EW-1] == (count_reg != '0))
        else $error("row head validity disagrees with entry count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.table_empty |->
            out_reg.last && out_reg.event_id == '0 && out_reg.event_time == '0)
        else $error("empty-table result carries data");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && fire && out_next.last |=> state_reg == ST_IDLE)
        else $error("sequencer stays busy after final event");

endmodule

### dv/pes_checker.sv
// Scoreboard for the periodic event scheduler: watches both channels,
// predicts the events of each accepted transaction and compares them in order.
// Depends on pes_pkg.
module pes_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  pes_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  pes_pkg::out_item_t out_data,
    output int                 error_count,
    output int                 pending_events,
    output int                 events_seen
);

    localparam int unsigned TABLE_DEPTH = pes_pkg::MAX_SOURCES_DEF;
    localparam int unsigned EMIT_LIMIT  = pes_pkg::MAX_EMITS_DEF;
    localparam logic [63:0] TIME_SAT    = (64'd1 << pes_pkg::TIME_BITS_DEF) - 64'd1;

    // Shadow copy of the source table.
    logic [pes_pkg::ID_W-1:0]     shadow_ids     [TABLE_DEPTH];
    logic [pes_pkg::PERIOD_W-1:0] shadow_periods [TABLE_DEPTH];
    logic [63:0]                  shadow_due     [TABLE_DEPTH];
    int unsigned                  shadow_count;

    pes_pkg::out_item_t expected_events[$];

    assign pending_events = expected_events.size();

    function automatic logic [63:0] add_saturate(logic [63:0] base, logic [63:0] step);
        logic [63:0] b;
        b = (base > TIME_SAT) ? TIME_SAT : base;
        if (step > TIME_SAT - b)
            return TIME_SAT;
        return b + step;
    endfunction

    // Apply one transaction to the shadow table and queue its events.
    task automatic schedule_transaction(pes_pkg::in_item_t item);
        int unsigned n;
        int unsigned best;
        pes_pkg::out_item_t ev;
        if (item.mode == pes_pkg::MODE_ADD)
        begin
            if (shadow_count < TABLE_DEPTH)
            begin
                shadow_ids[shadow_count]     = item.source_id;
                shadow_periods[shadow_count] = item.period;
                shadow_due[shadow_count]     = add_saturate(64'd0, 64'(item.period));
                shadow_count++;
            end
        end
        else if (item.mode == pes_pkg::MODE_CLEAR)
        begin
            shadow_count = 0;
        end
        else if (item.mode == pes_pkg::MODE_EMIT && item.emit_count != 0)
        begin
            n = (item.emit_count > EMIT_LIMIT) ? EMIT_LIMIT : item.emit_count;
            if (shadow_count == 0)
            begin
                ev = '0;
                ev.last = 1'b1;
                ev.table_empty = 1'b1;
                expected_events.push_back(ev);
            end
            else
            begin
                for (int unsigned k = 0; k < n; k++)
                begin
                    best = 0;
                    for (int unsigned i = 1; i < shadow_count; i++)
                    begin
                        if (shadow_due[i] < shadow_due[best] ||
                            (shadow_due[i] == shadow_due[best] &&
                             shadow_ids[i] < shadow_ids[best]))
                            best = i;
                    end
                    ev = '0;
                    ev.event_id   = shadow_ids[best];
                    ev.event_time = shadow_due[best][pes_pkg::OTIME_W-1:0];
                    ev.last       = (k + 1 == n);
                    expected_events.push_back(ev);
                    shadow_due[best] = add_saturate(shadow_due[best],
                                                    64'(shadow_periods[best]));
                end
            end
        end
    endtask

    // Watch both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pes_pkg::out_item_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            error_count  = 0;
            events_seen  = 0;
            expected_events.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                events_seen++;
                if (expected_events.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected event id=%h time=%h last=%b empty=%b",
                                 out_data.event_id, out_data.event_time,
                                 out_data.last, out_data.table_empty);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want.event_id !== out_data.event_id ||
                        want.event_time !== out_data.event_time ||
                        want.last !== out_data.last ||
                        want.table_empty !== out_data.table_empty)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"ERROR: event mismatch exp id=%h time=%h ",
                                      "last=%b empty=%b, got id=%h time=%h ",
                                      "last=%b empty=%b"},
                                     want.event_id, want.event_time, want.last,
                                     want.table_empty, out_data.event_id,
                                     out_data.event_time, out_data.last,
                                     out_data.table_empty);
                    end
                end
            end
            if (in_valid && !in_stall)
                schedule_transaction(in_data);
        end
    end
endmodule

### dv/tb_top.sv
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
// Depends on pes_pkg, periodic_event_scheduler and pes_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 2000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pes_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pes_pkg::out_item_t out_data;
    int                 error_count;
    int                 pending_events;
    int                 events_seen;
    int                 cycle_count = 0;
    int                 items_sent = 0;

    periodic_event_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    pes_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .error_count(error_count), .pending_events(pending_events),
        .events_seen(events_seen)
    );

    always #5 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver stalls a random number of cycles before each event;
    // some stretches run with no stall at all.
    initial
    begin
        int gap;
        bit calm;
        @(posedge rst_n);
        forever
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (20)
            begin
                gap = calm ? 0 : $urandom_range(0, 12);
                if (gap > 0)
                begin
                    @(negedge clk) out_stall <= 1'b1;
                    repeat (gap - 1) @(negedge clk);
                end
                @(negedge clk) out_stall <= 1'b0;
                do @(posedge clk); while (!out_valid);
            end
        end
    end

    // Send one transaction after a random pause; valid stays high
    // across back-to-back transactions.
    task automatic send_transaction(logic [1:0] mode, logic [pes_pkg::ID_W-1:0] sid,
                                    logic [pes_pkg::PERIOD_W-1:0] per,
                                    logic [pes_pkg::COUNT_W-1:0] cnt,
                                    bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.mode       <= mode;
        in_data.source_id  <= sid;
        in_data.period     <= per;
        in_data.emit_count <= cnt;
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_events != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        bit calm;
        int pick;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, zero count, reserved mode, extremes.
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd1, 0);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd0, 0);
        send_transaction(pes_pkg::MODE_RESERVED, '1, '1, '1, 0);
        send_transaction(pes_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, '0, 0);
        send_transaction(pes_pkg::MODE_ADD, 32'h0, 16'hFFFF, '0, 1);
        send_transaction(pes_pkg::MODE_ADD, 32'h5, 16'h0, '0, 1);
        send_transaction(pes_pkg::MODE_ADD, 32'hAAAA_5555, 16'h1, '0, 0);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd5, 0);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd127, 1);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd64, 0);
        send_transaction(pes_pkg::MODE_CLEAR, '0, '0, '0, 0);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd3, 0);
        // Fill past capacity with equal periods to exercise tie-breaking.
        for (int i = 0; i < 66; i++)
            send_transaction(pes_pkg::MODE_ADD, $urandom_range(0, 7), 16'd3, '0, 1);
        send_transaction(pes_pkg::MODE_EMIT, '0, '0, 7'd64, 0);
        // Let the full table drain before random traffic starts.
        wait_drained();
        send_transaction(pes_pkg::MODE_CLEAR, '0, '0, '0, 0);

        // Random: mostly adds and emits, with occasional clears and noise.
        for (int i = 0; i < 320; i++)
        begin
            calm = ((i / 40) % 3 == 2);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_transaction(pes_pkg::MODE_ADD, $urandom(),
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4))
                                                             : 16'($urandom()),
                                 7'($urandom()), calm);
            else if (pick < 90)
                send_transaction(pes_pkg::MODE_EMIT, $urandom(), 16'($urandom()),
                                 ($urandom_range(0, 4) == 0) ? 7'($urandom())
                                                             : 7'($urandom_range(1, 8)),
                                 calm);
            else if (pick < 95)
                send_transaction(pes_pkg::MODE_CLEAR, $urandom(), 16'($urandom()),
                                 7'($urandom()), calm);
            else
                send_transaction(pes_pkg::MODE_RESERVED, $urandom(), 16'($urandom()),
                                 7'($urandom()), calm);
            if (i == 160)
                wait_drained();
        end

        // Drain and give the verdict.
        wait_drained();
        repeat (20) @(negedge clk);
        $display("Sent %0d transactions and checked %0d events.", items_sent, events_seen);
        if (error_count == 0 && pending_events == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### periodic_event_scheduler.f
src/pes_pkg.sv
src/pes_cell.sv
src/periodic_event_scheduler.sv
dv/pes_checker.sv
dv/tb_top.sv
